### rtl/ebml_pkg.sv
// Shared types, widths, status codes and the lead byte decoder for the
// EBML element header decoder. No dependencies.

package ebml_pkg;

	localparam int ID_W    = 32;
	localparam int SIZE_W  = 56;
	localparam int COUNT_W = 5;
	localparam int LEFT_W  = 3;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_LEAD  = 2'd1;
	localparam logic [STAT_W-1:0] ST_TRUNCATED = 2'd2;

	localparam logic [COUNT_W-1:0] MAX_HEADER_BYTES = 5'd16;

	typedef struct packed {
		logic               active;
		logic               in_size_phase;
		logic [LEFT_W-1:0]  bytes_left;
		logic [ID_W-1:0]    id_accum;
		logic [SIZE_W-1:0]  size_accum;
		logic [COUNT_W-1:0] consumed_count;
	} dec_state_t;

	typedef struct packed {
		logic [ID_W-1:0]    element_id;
		logic [SIZE_W-1:0]  element_size;
		logic [COUNT_W-1:0] header_bytes;
		logic [STAT_W-1:0]  status;
	} hdr_t;

	typedef struct packed {
		logic              ok;
		logic [LEFT_W-1:0] more;
		logic [7:0]        payload;
	} lead_t;

	// more: bytes that follow the lead byte in the varint
	function automatic lead_t lead_decode(input logic [7:0] b);
		lead_t r;
		r = '0;
		if ((b & 8'h80) == 8'h80) begin
			r.ok = 1'b1; r.more = 3'd0; r.payload = b & 8'h7F;
		end else if ((b & 8'hC0) == 8'h40) begin
			r.ok = 1'b1; r.more = 3'd1; r.payload = b & 8'h3F;
		end else if ((b & 8'hE0) == 8'h20) begin
			r.ok = 1'b1; r.more = 3'd2; r.payload = b & 8'h1F;
		end else if ((b & 8'hF0) == 8'h10) begin
			r.ok = 1'b1; r.more = 3'd3; r.payload = b & 8'h0F;
		end else if (b == 8'h01) begin
			r.ok = 1'b1; r.more = 3'd7; r.payload = 8'h00;
		end
		return r;
	endfunction

endpackage

### rtl/ebml_if.sv
// Valid/ready channel interfaces: one for stream bytes, one for decoded headers.
// Depends on ebml_pkg.

interface ebml_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       header_start;
	logic       last_byte;

	modport source(output valid, data_byte, header_start, last_byte, input ready);
	modport sink(input valid, data_byte, header_start, last_byte, output ready);
endinterface

interface ebml_hdr_if;
	logic                        valid;
	logic                        ready;
	logic [ebml_pkg::ID_W-1:0]    element_id;
	logic [ebml_pkg::SIZE_W-1:0]  element_size;
	logic [ebml_pkg::COUNT_W-1:0] header_bytes;
	logic [ebml_pkg::STAT_W-1:0]  status;

	modport source(output valid, element_id, element_size, header_bytes, status,
		input ready);
	modport sink(input valid, element_id, element_size, header_bytes, status,
		output ready);
endinterface

### rtl/ebml_step.sv
// Next-state and result logic for one stream byte of the header decoder.
// Depends on ebml_pkg.

module ebml_step (
	input  ebml_pkg::dec_state_t state,
	input  logic [7:0]           data_byte,
	input  logic                 header_start,
	input  logic                 last_byte,
	output ebml_pkg::dec_state_t next_state,
	output logic                 emit,
	output ebml_pkg::hdr_t       result
);
	import ebml_pkg::*;

	always_comb begin
		dec_state_t n;
		lead_t      ld;
		logic       done;
		n    = state;
		ld   = lead_decode(data_byte);
		done = 1'b0;
		emit = 1'b0;
		result = '0;
		if (header_start) begin
			n = '0;
			n.active = 1'b1;
		end
		if (n.active) begin
			n.consumed_count = n.consumed_count + 1'b1;
			if (n.bytes_left == '0) begin
				if (!ld.ok) begin
					done = 1'b1;
					result.status = ST_BAD_LEAD;
				end else begin
					if (n.in_size_phase)
						n.size_accum = {{(SIZE_W-8){1'b0}}, ld.payload};
					else
						n.id_accum = {{(ID_W-8){1'b0}}, data_byte};
					n.bytes_left = ld.more;
				end
			end else begin
				if (n.in_size_phase)
					n.size_accum = {n.size_accum[SIZE_W-9:0], data_byte};
				else
					n.id_accum = {n.id_accum[ID_W-9:0], data_byte};
				n.bytes_left = n.bytes_left - 1'b1;
			end
			if (!done && n.bytes_left == '0) begin
				if (n.in_size_phase) begin
					done = 1'b1;
					result.status       = ST_OK;
					result.element_id   = n.id_accum;
					result.element_size = n.size_accum;
				end else begin
					n.in_size_phase = 1'b1;
				end
			end
			if (!done && last_byte) begin
				done = 1'b1;
				result.status = ST_TRUNCATED;
			end
			if (done) begin
				emit = 1'b1;
				result.header_bytes = n.consumed_count;
				n.active = 1'b0;
			end
		end
		next_state = n;
	end

endmodule

### rtl/ebml_element_header_decoder.sv
// Top level of the EBML element header decoder: input register, decode step,
// result register. Depends on ebml_pkg, ebml_if and ebml_step.

// One stream byte per cycle is accepted, sustained while results are taken,
// whatever the header lengths: a byte is captured in the input register,
// decoded by a single shift-and-mask step against the header state, and any
// finished header is then registered in the result register. While a result
// waits untaken, the byte in the input register waits with it, so the input
// stalls once that register is also full. A header start byte always restarts
// decoding; errors report status 1 (invalid lead) or 2 (buffer end).

module ebml_element_header_decoder (
	input logic        clk,
	input logic        arst_n,
	ebml_byte_if.sink  bytes,
	ebml_hdr_if.source headers
);
	import ebml_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       last_s1;

	dec_state_t state_q;
	dec_state_t state_d;
	logic       emit;
	hdr_t       result;

	logic       valid_s2;
	hdr_t       hdr_s2;
	logic       advance;

	assign advance     = !valid_s2 || headers.ready;
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1  <= bytes.data_byte;
			start_s1 <= bytes.header_start;
			last_s1  <= bytes.last_byte;
		end
	end

	ebml_step u_step (
		.state       (state_q),
		.data_byte   (byte_s1),
		.header_start(start_s1),
		.last_byte   (last_s1),
		.next_state  (state_d),
		.emit        (emit),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit;
			if (valid_s1)
				state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit)
			hdr_s2 <= result;
	end

	assign headers.valid        = valid_s2;
	assign headers.element_id   = hdr_s2.element_id;
	assign headers.element_size = hdr_s2.element_size;
	assign headers.header_bytes = hdr_s2.header_bytes;
	assign headers.status       = hdr_s2.status;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		headers.valid && headers.status != ST_OK
		|-> headers.element_id == '0 && headers.element_size == '0)
		else $error("error header carries nonzero id or size");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		headers.valid |-> headers.header_bytes != '0
		&& headers.header_bytes <= MAX_HEADER_BYTES)
		else $error("header byte count out of range");

	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		headers.valid && headers.status == ST_OK |-> headers.header_bytes >= 5'd2)
		else $error("complete header shorter than two bytes");

	a_stall_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(state_q))
		else $error("input stage lost an item while stalled");
`endif

endmodule
